// ===== rtl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, codes and the CRC-32 byte update of the packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int unsigned HEADER_BYTES = 20;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam logic [31:0] MAGIC_RESET     = 32'h0000_0000;
    localparam logic [7:0]  END_RESET       = 8'h00;
    localparam logic [31:0] REPLY_RESET     = 32'h8000_0000;
    localparam logic [31:0] MAX_LEN_RESET   = 32'd67108864;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_TERM   = 3'd3,
        ST_CRC       = 3'd4
    } cpd_status_t;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_END     = 2'd1,
        REG_REPLY   = 2'd2,
        REG_MAX_LEN = 2'd3
    } cpd_reg_idx_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  end_marker;
        logic [31:0] reply_flag_mask;
        logic [31:0] max_payload;
    } cpd_cfg_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [31:0] stream_id;
        logic [31:0] msg_id;
        logic        reply_flag;
        logic [31:0] payload_length;
        cpd_status_t status;
    } cpd_result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/cpd_regs.sv =====
// ----------------------------------------------------------------------------
// cpd_regs
// APB configuration registers of the packet deframer.
// ----------------------------------------------------------------------------
module cpd_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cpd_pkg::cpd_cfg_t cfg
);
    import cpd_pkg::*;

    cpd_cfg_t     cfg_reg;
    cpd_reg_idx_t idx;
    logic         wr_en;

    assign idx    = cpd_reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word      <= MAGIC_RESET;
            cfg_reg.end_marker      <= END_RESET;
            cfg_reg.reply_flag_mask <= REPLY_RESET;
            cfg_reg.max_payload     <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAGIC:   cfg_reg.magic_word      <= pwdata;
                REG_END:     cfg_reg.end_marker      <= pwdata[7:0];
                REG_REPLY:   cfg_reg.reply_flag_mask <= pwdata;
                REG_MAX_LEN: cfg_reg.max_payload     <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAGIC:   prdata = cfg_reg.magic_word;
            REG_END:     prdata = {24'd0, cfg_reg.end_marker};
            REG_REPLY:   prdata = cfg_reg.reply_flag_mask;
            REG_MAX_LEN: prdata = cfg_reg.max_payload;
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/cpd_front.sv =====
// ----------------------------------------------------------------------------
// cpd_front
// Byte parser: header assembly, running CRC-32, payload pass-through and
// packet end classification. Emits at most one result per accepted byte.
// ----------------------------------------------------------------------------
module cpd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpd_pkg::cpd_cfg_t    cfg,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output logic                 push,
    output cpd_pkg::cpd_result_t item
);
    import cpd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TERM    = 2'd2
    } phase_t;

    localparam logic [4:0] LAST_HDR = 5'(HEADER_BYTES - 1);

    phase_t      phase_reg, phase_next;
    logic [4:0]  hcount_reg, hcount_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] checksum_reg, checksum_next;
    logic [31:0] stream_reg, stream_next;
    logic [31:0] msgword_reg, msgword_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] crc_reg, crc_next;

    logic        end_rec;
    cpd_status_t end_status;
    logic [2:0]  group;

    assign group = hcount_reg[4:2];

    always_comb
    begin
        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        magic_next    = magic_reg;
        checksum_next = checksum_reg;
        stream_next   = stream_reg;
        msgword_next  = msgword_reg;
        length_next   = length_reg;
        left_next     = left_reg;
        crc_next      = crc_reg;
        end_rec       = 1'b0;
        end_status    = ST_OK;
        push          = 1'b0;
        item          = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    crc_next          = crc32_byte(crc_reg, rx_byte);
                    left_next         = left_reg - 32'd1;
                    push              = 1'b1;
                    item.result_kind  = KIND_BYTE;
                    item.payload_byte = rx_byte;
                    if (left_reg == 32'd1)
                    begin
                        phase_next = PH_TERM;
                    end
                end
                PH_TERM:
                begin
                    end_rec = 1'b1;
                    if (rx_byte != cfg.end_marker)
                    begin
                        end_status = ST_NO_TERM;
                    end
                    else if ((crc_reg ^ CRC_INIT) != checksum_reg)
                    begin
                        end_status = ST_CRC;
                    end
                    else
                    begin
                        end_status = ST_OK;
                    end
                end
                default:
                begin
                    case (group)
                        3'd0:    magic_next    = {magic_reg[23:0], rx_byte};
                        3'd1:    checksum_next = {checksum_reg[23:0], rx_byte};
                        3'd2:    stream_next   = {stream_reg[23:0], rx_byte};
                        3'd3:    msgword_next  = {msgword_reg[23:0], rx_byte};
                        default: length_next   = {length_reg[23:0], rx_byte};
                    endcase
                    crc_next    = crc32_byte(crc_reg, (group == 3'd1) ? 8'd0 : rx_byte);
                    hcount_next = hcount_reg + 5'd1;
                    phase_next  = PH_HEADER;
                    if (hcount_reg >= LAST_HDR)
                    begin
                        hcount_next = 5'd0;
                        if (magic_reg != cfg.magic_word)
                        begin
                            end_rec    = 1'b1;
                            end_status = ST_BAD_MAGIC;
                        end
                        else if (length_next > cfg.max_payload)
                        begin
                            end_rec    = 1'b1;
                            end_status = ST_TOO_LARGE;
                        end
                        else if (length_next == 32'd0)
                        begin
                            phase_next = PH_TERM;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            left_next  = length_next;
                        end
                    end
                end
            endcase

            if (end_rec)
            begin
                push                = 1'b1;
                item.result_kind    = KIND_END;
                item.stream_id      = stream_next;
                item.msg_id         = msgword_next & ~cfg.reply_flag_mask;
                item.reply_flag     = |(msgword_next & cfg.reply_flag_mask);
                item.payload_length = length_next;
                item.status         = end_status;
                phase_next          = PH_HEADER;
                hcount_next         = 5'd0;
                left_next           = 32'd0;
                crc_next            = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hcount_reg   <= 5'd0;
            magic_reg    <= 32'd0;
            checksum_reg <= 32'd0;
            stream_reg   <= 32'd0;
            msgword_reg  <= 32'd0;
            length_reg   <= 32'd0;
            left_reg     <= 32'd0;
            crc_reg      <= CRC_INIT;
        end
        else
        begin
            phase_reg    <= phase_next;
            hcount_reg   <= hcount_next;
            magic_reg    <= magic_next;
            checksum_reg <= checksum_next;
            stream_reg   <= stream_next;
            msgword_reg  <= msgword_next;
            length_reg   <= length_next;
            left_reg     <= left_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

// ===== rtl/cpd_back.sv =====
// ----------------------------------------------------------------------------
// cpd_back
// Result queue between the parser and the output channel; its head is the
// output transaction.
// ----------------------------------------------------------------------------
module cpd_back #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cpd_pkg::cpd_result_t item,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cpd_pkg::cpd_result_t out_item
);
    import cpd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cpd_result_t      queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_item  = queue_reg[rd_ptr_reg];
    assign pop       = out_valid & ~out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== rtl/crc_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// crc_packet_deframer_core
// Length-prefixed packet deframer with CRC-32 check.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle, back to back, and emits at most one
// transaction per byte: either the payload byte itself or a packet end record
// with stream, message id, reply flag, length and status. The rate of one byte
// per cycle is set by the parser, which does a full bytewise CRC-32 update and
// the header length compare combinationally. Results wait in a queue of
// QUEUE_DEPTH entries; input stalls only while that queue is full. The user
// writes the configuration registers over APB only while no packet is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module crc_packet_deframer_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 result_kind,
    output logic [7:0]           payload_byte,
    output logic [31:0]          stream_id,
    output logic [31:0]          msg_id,
    output logic                 reply_flag,
    output logic [31:0]          payload_length,
    output logic [2:0]           status
);
    import cpd_pkg::*;

    cpd_cfg_t    cfg;
    cpd_result_t front_item;
    cpd_result_t out_item;
    logic        front_push;
    logic        queue_full;
    logic        accept;

    assign in_stall = queue_full;
    assign accept   = in_valid & ~queue_full;

    cpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .rx_byte (rx_byte),
        .push    (front_push),
        .item    (front_item)
    );

    cpd_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .item      (front_item),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign result_kind    = out_item.result_kind;
    assign payload_byte   = out_item.payload_byte;
    assign stream_id      = out_item.stream_id;
    assign msg_id         = out_item.msg_id;
    assign reply_flag     = out_item.reply_flag;
    assign payload_length = out_item.payload_length;
    assign status         = out_item.status;

endmodule

// ===== rtl/cpd_checker.sv =====
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        result_kind,
    input logic [7:0]  payload_byte,
    input logic [31:0] stream_id,
    input logic [31:0] msg_id,
    input logic        reply_flag,
    input logic [31:0] payload_length,
    input logic [2:0]  status
);
    import cpd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(stream_id) && $stable(status))
        else $error("stalled output transaction changed");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_BYTE |-> stream_id == 32'd0
            && msg_id == 32'd0 && !reply_flag && payload_length == 32'd0
            && status == ST_OK)
        else $error("payload byte carries record fields");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_END |-> payload_byte == 8'd0)
        else $error("end record carries a payload byte");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_BAD_MAGIC
            || status == ST_TOO_LARGE || status == ST_NO_TERM || status == ST_CRC)
        else $error("undefined status code");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending output");

endmodule

bind crc_packet_deframer_core cpd_checker u_cpd_checker (.*);

// ===== test/tb_crc_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tb_crc_packet_deframer_core
// Self-checking testbench for the CRC-32 packet deframer.
// ----------------------------------------------------------------------------
// Sends whole packets (good ones, bad magic, oversize length, wrong terminator,
// wrong checksum), cut-off packets and line noise through the byte input,
// under several register settings written over APB between packets. A
// scoreboard predicts every passed-through byte and every end record from the
// accepted bytes and checks each output transaction in order. Both sides idle
// at random, and once the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_crc_packet_deframer_core;
    import cpd_pkg::*;

    typedef enum logic [1:0] {
        AT_HEADER  = 2'd0,
        AT_PAYLOAD = 2'd1,
        AT_TERM    = 2'd2
    } parse_phase_t;

    typedef enum int {
        PKT_GOOD,
        PKT_BAD_MAGIC,
        PKT_TOO_LARGE,
        PKT_NO_TERM,
        PKT_BAD_CRC,
        PKT_TRUNC
    } pkt_kind_t;

    class deframer_scoreboard;
        logic [31:0]   magic_word;
        logic [7:0]    end_marker;
        logic [31:0]   reply_mask;
        logic [31:0]   max_len;

        parse_phase_t  phase;
        int unsigned   hdr_count;
        logic [31:0]   magic_acc;
        logic [31:0]   csum_acc;
        logic [31:0]   stream_acc;
        logic [31:0]   msg_acc;
        logic [31:0]   len_acc;
        logic [31:0]   bytes_to_go;
        logic [31:0]   crc;

        cpd_result_t   due_results[$];

        function new();
            magic_word  = MAGIC_RESET;
            end_marker  = END_RESET;
            reply_mask  = REPLY_RESET;
            max_len     = MAX_LEN_RESET;
            magic_acc   = '0;
            csum_acc    = '0;
            stream_acc  = '0;
            msg_acc     = '0;
            len_acc     = '0;
            restart();
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] v;
            v = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            return v;
        endfunction

        function void restart();
            phase       = AT_HEADER;
            hdr_count   = 0;
            bytes_to_go = '0;
            crc         = CRC_INIT;
        endfunction

        function void write_register(cpd_reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_MAGIC:   magic_word = v;
                REG_END:     end_marker = v[7:0];
                REG_REPLY:   reply_mask = v;
                REG_MAX_LEN: max_len    = v;
                default:     ;
            endcase
        endfunction

        function logic [31:0] register_value(cpd_reg_idx_t idx);
            case (idx)
                REG_MAGIC:   return magic_word;
                REG_END:     return {24'd0, end_marker};
                REG_REPLY:   return reply_mask;
                default:     return max_len;
            endcase
        endfunction

        function bit at_boundary();
            return phase == AT_HEADER && hdr_count == 0;
        endfunction

        function void close_packet(cpd_status_t st);
            cpd_result_t r;
            r                = '0;
            r.result_kind    = KIND_END;
            r.stream_id      = stream_acc;
            r.msg_id         = msg_acc & ~reply_mask;
            r.reply_flag     = |(msg_acc & reply_mask);
            r.payload_length = len_acc;
            r.status         = st;
            due_results.push_back(r);
            restart();
        endfunction

        function void note_rx_byte(logic [7:0] b);
            cpd_result_t r;
            r = '0;
            case (phase)
                AT_PAYLOAD:
                begin
                    crc            = crc_step(crc, b);
                    r.result_kind  = KIND_BYTE;
                    r.payload_byte = b;
                    due_results.push_back(r);
                    bytes_to_go    = bytes_to_go - 1;
                    if (bytes_to_go == 0)
                        phase = AT_TERM;
                end
                AT_TERM:
                begin
                    if (b != end_marker)
                        close_packet(ST_NO_TERM);
                    else if (~crc != csum_acc)
                        close_packet(ST_CRC);
                    else
                        close_packet(ST_OK);
                end
                default:
                begin
                    case (hdr_count / 4)
                        0:       magic_acc  = {magic_acc[23:0], b};
                        1:       csum_acc   = {csum_acc[23:0], b};
                        2:       stream_acc = {stream_acc[23:0], b};
                        3:       msg_acc    = {msg_acc[23:0], b};
                        default: len_acc    = {len_acc[23:0], b};
                    endcase
                    crc = crc_step(crc, (hdr_count / 4 == 1) ? 8'h00 : b);
                    hdr_count++;
                    if (hdr_count == HEADER_BYTES) begin
                        if (magic_acc != magic_word)
                            close_packet(ST_BAD_MAGIC);
                        else if (len_acc > max_len)
                            close_packet(ST_TOO_LARGE);
                        else begin
                            hdr_count = 0;
                            if (len_acc == 0)
                                phase = AT_TERM;
                            else begin
                                phase       = AT_PAYLOAD;
                                bytes_to_go = len_acc;
                            end
                        end
                    end
                end
            endcase
        endfunction

        function string check_output(cpd_result_t got);
            cpd_result_t want;
            string       diffs;
            if (due_results.size() == 0)
                return $sformatf("unexpected transaction kind=%0d byte=%02h status=%0d",
                                 got.result_kind, got.payload_byte, got.status);
            want  = due_results.pop_front();
            diffs = "";
            if (got.result_kind !== want.result_kind)
                diffs = {diffs, $sformatf(" result_kind %0d want %0d",
                                          got.result_kind, want.result_kind)};
            if (got.payload_byte !== want.payload_byte)
                diffs = {diffs, $sformatf(" payload_byte %02h want %02h",
                                          got.payload_byte, want.payload_byte)};
            if (got.stream_id !== want.stream_id)
                diffs = {diffs, $sformatf(" stream_id %08h want %08h",
                                          got.stream_id, want.stream_id)};
            if (got.msg_id !== want.msg_id)
                diffs = {diffs, $sformatf(" msg_id %08h want %08h",
                                          got.msg_id, want.msg_id)};
            if (got.reply_flag !== want.reply_flag)
                diffs = {diffs, $sformatf(" reply_flag %0d want %0d",
                                          got.reply_flag, want.reply_flag)};
            if (got.payload_length !== want.payload_length)
                diffs = {diffs, $sformatf(" payload_length %08h want %08h",
                                          got.payload_length, want.payload_length)};
            if (got.status !== want.status)
                diffs = {diffs, $sformatf(" status %0d want %0d", got.status, want.status)};
            return diffs;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] stream_id;
    logic [31:0] msg_id;
    logic        reply_flag;
    logic [31:0] payload_length;
    logic [2:0]  status;

    deframer_scoreboard sb = new();
    int unsigned        errors      = 0;
    int unsigned        sent_total  = 0;
    bit                 idle_on     = 1'b1;
    bit                 pressure_go = 1'b0;

    crc_packet_deframer_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .stream_id      (stream_id),
        .msg_id         (msg_id),
        .reply_flag     (reply_flag),
        .payload_length (payload_length),
        .status         (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("error at %0t:%s", $realtime, what);
    endtask

    // hold off the output side: random idling, plus one long stretch on request
    initial
    begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_go) begin
                pressure_go = 1'b0;
                for (int n = 0; n < 200; n++) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= idle_on && ($urandom_range(99) < 25);
        end
    end

    always @(negedge clk)
    begin
        cpd_result_t got;
        string       diffs;
        if (rst_n && out_valid && !out_stall) begin
            got.result_kind    = result_kind;
            got.payload_byte   = payload_byte;
            got.stream_id      = stream_id;
            got.msg_id         = msg_id;
            got.reply_flag     = reply_flag;
            got.payload_length = payload_length;
            got.status         = cpd_status_t'(status);
            diffs = sb.check_output(got);
            if (diffs != "")
                report_mismatch(diffs);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        bit stalled;
        while (idle_on && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        sb.note_rx_byte(b);
        sent_total++;
    endtask

    // drive the parser back to the start of a header
    task automatic sync_stream();
        logic [7:0] fill;
        while (!sb.at_boundary()) begin
            if (sb.phase == AT_HEADER && sb.hdr_count < 4)
                fill = ~sb.magic_word[31 - 8 * sb.hdr_count -: 8];
            else if (sb.phase == AT_HEADER)
                fill = 8'h00;
            else
                fill = 8'($urandom);
            send_byte(fill);
        end
    endtask

    task automatic push_word(ref logic [7:0] q[$], input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            q.push_back(w[31 - 8 * i -: 8]);
    endtask

    task automatic send_packet(input pkt_kind_t kind, input logic [31:0] len,
                               input logic [31:0] stream, input logic [31:0] msg);
        logic [7:0]  pkt[$];
        logic [31:0] magic;
        logic [31:0] c;
        int unsigned cut;
        sync_stream();
        if (kind == PKT_TOO_LARGE && sb.max_len == 32'hFFFF_FFFF)
            kind = PKT_BAD_MAGIC;
        magic = sb.magic_word;
        if (kind == PKT_BAD_MAGIC)
            magic = magic ^ (32'h1 << $urandom_range(31));
        if (kind == PKT_TOO_LARGE)
            len = sb.max_len + 1 +
                  (($urandom_range(99) < 50) ? 0 : $urandom % (32'hFFFF_FFFF - sb.max_len));
        else if (kind != PKT_BAD_MAGIC && len > sb.max_len)
            len = sb.max_len;
        push_word(pkt, magic);
        push_word(pkt, 32'h0);
        push_word(pkt, stream);
        push_word(pkt, msg);
        push_word(pkt, len);
        if (kind != PKT_BAD_MAGIC && kind != PKT_TOO_LARGE) begin
            for (int i = 0; i < len; i++)
                pkt.push_back(8'($urandom));
            c = CRC_INIT;
            foreach (pkt[i])
                c = deframer_scoreboard::crc_step(c, pkt[i]);
            c = ~c;
            if (kind == PKT_BAD_CRC)
                c = c ^ (32'h1 << $urandom_range(31));
            for (int i = 0; i < 4; i++)
                pkt[4 + i] = c[31 - 8 * i -: 8];
            if (kind == PKT_NO_TERM)
                pkt.push_back(sb.end_marker ^ 8'($urandom_range(255, 1)));
            else
                pkt.push_back(sb.end_marker);
        end
        cut = (kind == PKT_TRUNC) ? $urandom_range(pkt.size() - 1, 1) : pkt.size();
        for (int i = 0; i < cut; i++)
            send_byte(pkt[i]);
    endtask

    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(30, 1);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom));
    endtask

    task automatic run_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        logic [31:0] len;
        start = sent_total;
        while (sent_total - start < budget) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(40, 9);
            if (pick < 60)
                send_packet(PKT_GOOD, len, $urandom, $urandom);
            else if (pick < 68)
                send_packet(PKT_BAD_MAGIC, $urandom, $urandom, $urandom);
            else if (pick < 74)
                send_packet(PKT_TOO_LARGE, len, $urandom, $urandom);
            else if (pick < 82)
                send_packet(PKT_NO_TERM, len, $urandom, $urandom);
            else if (pick < 90)
                send_packet(PKT_BAD_CRC, len, $urandom, $urandom);
            else if (pick < 95)
                send_packet(PKT_TRUNC, len, $urandom, $urandom);
            else
                send_noise();
        end
        sync_stream();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input cpd_reg_idx_t idx, input logic [31:0] v);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(idx, v);
    endtask

    task automatic apb_check(input cpd_reg_idx_t idx);
        bit          rdy;
        logic [31:0] data;
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
            rdy  = pready;
            data = prdata;
            @(posedge clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        mask = (idx == REG_END) ? 32'h0000_00FF : 32'hFFFF_FFFF;
        if ((data & mask) !== sb.register_value(idx))
            report_mismatch($sformatf(" register %0d reads %08h want %08h",
                                      idx, data, sb.register_value(idx)));
    endtask

    task automatic load_settings(input logic [31:0] magic, input logic [7:0] term,
                                 input logic [31:0] reply, input logic [31:0] max_len);
        apb_write(REG_MAGIC, magic);
        apb_write(REG_END, {24'd0, term});
        apb_write(REG_REPLY, reply);
        apb_write(REG_MAX_LEN, max_len);
        apb_check(REG_MAGIC);
        apb_check(REG_END);
        apb_check(REG_REPLY);
        apb_check(REG_MAX_LEN);
    endtask

    initial
    begin
        #5000000;
        $display("crc_packet_deframer_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        rx_byte  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: magic 0, terminator 0, top-bit reply flag, 64 MiB limit
        send_packet(PKT_GOOD, 0, 32'h0000_0000, 32'h8000_0001);
        send_packet(PKT_GOOD, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_packet(PKT_GOOD, 3, 32'h1234_5678, 32'hFFFF_FFFF);
        send_packet(PKT_BAD_MAGIC, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h0000_0000);
        send_packet(PKT_TOO_LARGE, 0, 32'h0000_0001, 32'h8000_0000);
        send_packet(PKT_NO_TERM, 2, 32'h0F0F_0F0F, 32'h0000_00FF);
        send_packet(PKT_BAD_CRC, 2, 32'hF0F0_F0F0, 32'hFF00_0000);
        send_packet(PKT_TRUNC, 4, 32'h0000_0002, 32'h0000_0003);
        run_traffic(130);
        settle();

        load_settings(32'hCAFE_F00D, 8'h7E, 32'h0000_0101, 32'd16);
        run_traffic(150);
        settle();

        idle_on = 1'b0;
        load_settings(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_traffic(150);
        settle();
        idle_on = 1'b1;

        load_settings(32'h0000_0000, 8'h00, 32'h0000_0000, 32'h0000_0000);
        run_traffic(120);
        settle();

        load_settings($urandom, 8'($urandom), 32'h1 << $urandom_range(31),
                      $urandom_range(64, 8));
        pressure_go = 1'b1;
        run_traffic(170);
        settle();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("crc_packet_deframer_core: match");
        else
            $display("crc_packet_deframer_core: mismatch");
        $finish;
    end

endmodule
